FILE: sv/tcpq_pkg.sv
// tcpq_pkg: shared types and codes for the three-class priority call queue.
// Used by the front, back, FIFO, checker and top level. No dependencies.

package tcpq_pkg;

  // Fixed port widths
  localparam int PORT_PAYLOAD_BITS = 32;
  localparam int TOTAL_BITS        = 6;

  // Class codes
  localparam logic [1:0] CLS_EMERGENCY = 2'd0;
  localparam logic [1:0] CLS_VOICE     = 2'd1;
  localparam logic [1:0] CLS_DATA      = 2'd2;
  localparam int         NUM_CLASSES   = 3;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_SERVE   = 2'd1,
    OP_DISMISS = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // Classified command item, front to back
  typedef struct packed {
    op_t                          op;
    logic [1:0]                   cls;
    logic [PORT_PAYLOAD_BITS-1:0] payload;
  } cmd_t;

  // Result item, back to output queue
  typedef struct packed {
    logic                         served_valid;
    logic [1:0]                   served_class;
    logic [PORT_PAYLOAD_BITS-1:0] served_payload;
    logic [TOTAL_BITS-1:0]        total_count;
    logic                         queue_empty;
    status_t                      status;
  } res_t;

  // FIFO occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } fifo_stat_t;

endpackage

FILE: sv/tcpq_fifo.sv
// tcpq_fifo: small register FIFO used for the command queue and result queue.
// Depends on tcpq_pkg (fifo_stat_t).

module tcpq_fifo
  import tcpq_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output fifo_stat_t       stat
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CNTW-1:0]  count;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  assign rd_data    = mem[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNTW'(DEPTH));
  assign stat.afull = (count >= CNTW'(DEPTH - 1));

endmodule

FILE: sv/tcpq_front.sv
// tcpq_front: input stage; accepts command items, normalizes the class code
// and hands them to the command queue. Depends on tcpq_pkg.

module tcpq_front
  import tcpq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic [1:0]                   call_class,
  input  logic [PORT_PAYLOAD_BITS-1:0] payload_in,
  input  logic                         cq_full,
  output logic                         cq_push,
  output cmd_t                         cq_data
);

  logic fr_valid, fr_valid_next;
  cmd_t fr_cmd;
  logic accept;

  assign full    = fr_valid && cq_full;
  assign accept  = push && !full;
  assign cq_push = fr_valid && !cq_full;
  assign cq_data = fr_cmd;

  // Stage occupancy
  always_comb begin
    fr_valid_next = accept || (fr_valid && cq_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  // Classify: class code three maps to data
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd.op      <= op_t'(command);
      fr_cmd.cls     <= (call_class > CLS_DATA) ? CLS_DATA : call_class;
      fr_cmd.payload <= payload_in;
    end
  end

endmodule

FILE: sv/tcpq_back.sv
// tcpq_back: executes commands against the three class FIFOs (memories plus
// head/tail/count registers) and builds result items. Depends on tcpq_pkg.

module tcpq_back
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cq_empty,
  input  cmd_t       cq_data,
  output logic       cq_pop,
  input  fifo_stat_t oq_stat,
  output logic       res_push,
  output res_t       res
);

  localparam int PW  = $clog2(CLASS_DEPTH);
  localparam int CW  = $clog2(CLASS_DEPTH + 1);
  localparam int SW  = (PAYLOAD_BITS < PORT_PAYLOAD_BITS) ? PAYLOAD_BITS : PORT_PAYLOAD_BITS;
  localparam int TW  = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);
  localparam int TXW = (TW > TOTAL_BITS) ? TW : TOTAL_BITS;

  logic [PW-1:0] head [NUM_CLASSES];
  logic [PW-1:0] tail [NUM_CLASSES];
  logic [CW-1:0] cnt  [NUM_CLASSES];
  logic [PW-1:0] head_next [NUM_CLASSES];
  logic [PW-1:0] tail_next [NUM_CLASSES];
  logic [CW-1:0] cnt_next  [NUM_CLASSES];

  logic [NUM_CLASSES-1:0] wr_en, rd_en, sel, cls_full;
  logic [SW-1:0]          wr_data;
  logic [SW-1:0]          rd_q [NUM_CLASSES];

  logic          fire;
  logic          enq_full;
  logic [TW-1:0] total;
  logic [TXW-1:0] total_x;
  status_t       status_next;
  logic          srv_next;
  logic [1:0]    srv_cls_next;

  // Stage 2 registers
  logic                  s2_valid;
  logic                  s2_srv;
  logic [1:0]            s2_cls;
  logic [TOTAL_BITS-1:0] s2_total;
  logic                  s2_empty;
  status_t               s2_status;
  logic [SW-1:0]         s2_pay;

  // Issue when the result queue has room for this item and the one in flight
  assign fire   = !cq_empty && (s2_valid ? !oq_stat.afull : !oq_stat.full);
  assign cq_pop = fire;
  assign wr_data = SW'(cq_data.payload);

  // Stage 1: priority select, pointer and count updates
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cls_full[k] = (cnt[k] == CW'(CLASS_DEPTH));
    end
    sel[0] = (cnt[0] != '0);
    sel[1] = (cnt[0] == '0) && (cnt[1] != '0);
    sel[2] = (cnt[0] == '0) && (cnt[1] == '0) && (cnt[2] != '0);

    enq_full = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (cq_data.cls == 2'(k) && cls_full[k]) begin
        enq_full = 1'b1;
      end
    end

    for (int k = 0; k < NUM_CLASSES; k++) begin
      wr_en[k] = fire && (cq_data.op == OP_ENQ) && (cq_data.cls == 2'(k)) && !cls_full[k];
      rd_en[k] = fire && (cq_data.op == OP_SERVE) && sel[k];
      head_next[k] = head[k];
      tail_next[k] = tail[k];
      cnt_next[k]  = cnt[k];
      if (fire && (cq_data.op == OP_DISMISS) && (2'(k) == CLS_DATA)) begin
        head_next[k] = '0;
        tail_next[k] = '0;
        cnt_next[k]  = '0;
      end else if (wr_en[k]) begin
        tail_next[k] = (tail[k] == PW'(CLASS_DEPTH - 1)) ? '0 : tail[k] + 1'b1;
        cnt_next[k]  = cnt[k] + 1'b1;
      end else if (rd_en[k]) begin
        head_next[k] = (head[k] == PW'(CLASS_DEPTH - 1)) ? '0 : head[k] + 1'b1;
        cnt_next[k]  = cnt[k] - 1'b1;
      end
    end

    total   = TW'(cnt_next[0]) + TW'(cnt_next[1]) + TW'(cnt_next[2]);
    total_x = TXW'(total);

    srv_next     = (cq_data.op == OP_SERVE) && (sel != '0);
    srv_cls_next = sel[0] ? CLS_EMERGENCY : (sel[1] ? CLS_VOICE : CLS_DATA);

    status_next = ST_OK;
    case (cq_data.op)
      OP_ENQ:   status_next = enq_full ? ST_DROPPED : ST_OK;
      OP_SERVE: status_next = (sel == '0) ? ST_EMPTY : ST_OK;
      default:  status_next = ST_OK;
    endcase
  end

  // Class state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        cnt[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head[k] <= head_next[k];
        tail[k] <= tail_next[k];
        cnt[k]  <= cnt_next[k];
      end
    end
  end

  // One payload memory per class, registered read
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_store
    logic [SW-1:0] store [CLASS_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en[g]) begin
        store[tail[g]] <= wr_data;
      end
      if (rd_en[g]) begin
        rd_q[g] <= store[head[g]];
      end
    end
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_srv    <= srv_next;
      s2_cls    <= srv_next ? srv_cls_next : CLS_EMERGENCY;
      s2_total  <= total_x[TOTAL_BITS-1:0];
      s2_empty  <= (total == '0);
      s2_status <= status_next;
    end
  end

  // Pick the read data of the served class
  always_comb begin
    s2_pay = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (s2_srv && s2_cls == 2'(k)) begin
        s2_pay = rd_q[k];
      end
    end
  end

  assign res_push           = s2_valid;
  assign res.served_valid   = s2_srv;
  assign res.served_class   = s2_cls;
  assign res.served_payload = PORT_PAYLOAD_BITS'(s2_pay);
  assign res.total_count    = s2_total;
  assign res.queue_empty    = s2_empty;
  assign res.status         = s2_status;

endmodule

FILE: sv/three_class_priority_call_queue.sv
// Three-class strict-priority call queue: emergency, voice, data.
// Path of an item: front register, command queue, back stage 2 registers, result queue.
// Throughput: one item per cycle unless a full result queue holds up the back part.
// Reset (rst, synchronous): empties command and result queues, clears all class
// heads, tails and counts; payload memories are not cleared.
// Depends on tcpq_pkg, tcpq_fifo, tcpq_front, tcpq_back.

module three_class_priority_call_queue
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic [1:0]                   call_class,
  input  logic [PORT_PAYLOAD_BITS-1:0] payload_in,
  output logic                         empty,
  input  logic                         pop,
  output logic                         served_valid,
  output logic [1:0]                   served_class,
  output logic [PORT_PAYLOAD_BITS-1:0] served_payload,
  output logic [TOTAL_BITS-1:0]        total_count,
  output logic                         queue_empty,
  output logic [1:0]                   status
);

  localparam int QUEUE_DEPTH = 4;

  cmd_t       cq_wdata, cq_rdata;
  logic       cq_push, cq_pop;
  fifo_stat_t cq_stat, oq_stat;
  res_t       res_w, res_r;
  logic       res_push, oq_pop;

  // Front: accept and classify
  tcpq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .call_class (call_class),
    .payload_in (payload_in),
    .cq_full    (cq_stat.full),
    .cq_push    (cq_push),
    .cq_data    (cq_wdata)
  );

  // Command queue between front and back
  tcpq_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_data (cq_wdata),
    .rd_en   (cq_pop),
    .rd_data (cq_rdata),
    .stat    (cq_stat)
  );

  // Back: execute against class FIFOs
  tcpq_back #(
    .CLASS_DEPTH  (CLASS_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_empty (cq_stat.empty),
    .cq_data  (cq_rdata),
    .cq_pop   (cq_pop),
    .oq_stat  (oq_stat),
    .res_push (res_push),
    .res      (res_w)
  );

  // Result queue
  tcpq_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_w),
    .rd_en   (oq_pop),
    .rd_data (res_r),
    .stat    (oq_stat)
  );

  assign empty          = oq_stat.empty;
  assign oq_pop         = pop && !oq_stat.empty;
  assign served_valid   = res_r.served_valid;
  assign served_class   = res_r.served_class;
  assign served_payload = res_r.served_payload;
  assign total_count    = res_r.total_count;
  assign queue_empty    = res_r.queue_empty;
  assign status         = res_r.status;

endmodule

FILE: sv/tcpq_checker.sv
// tcpq_checker: port-level assertions for the call queue, bound to the top.
// Depends on tcpq_pkg and three_class_priority_call_queue.

module tcpq_checker
  import tcpq_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic                         served_valid,
  input logic [PORT_PAYLOAD_BITS-1:0] served_payload,
  input logic [TOTAL_BITS-1:0]        total_count,
  input logic                         queue_empty,
  input logic [1:0]                   status
);

  // Result queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A waiting item is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting item vanished without pop");

  // No item served means a zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && !served_valid) |-> (served_payload == '0))
    else $error("payload nonzero on a non-serve item");

  // Serve on empty leaves nothing queued and returns nothing
  a_empty_serve: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_EMPTY) |-> (!served_valid && queue_empty))
    else $error("serve-on-empty item inconsistent");

  // Empty flag agrees with the count
  a_count_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && queue_empty) |-> (total_count == '0))
    else $error("queue_empty set with nonzero count");

endmodule

bind three_class_priority_call_queue tcpq_checker u_tcpq_checker (.*);
